// File: hdl/sbsr_pkg.sv
// ----------------------------------------------------------------------------
// sbsr_pkg
// Shared types and constants of the servo-bus status responder.
// ----------------------------------------------------------------------------
package sbsr_pkg;

    // Instruction codes and control table addresses
    localparam logic [7:0] INS_PING   = 8'd1;
    localparam logic [7:0] INS_READ   = 8'd2;
    localparam logic [7:0] INS_WRITE  = 8'd3;
    localparam logic [7:0] GOAL_REG   = 8'd30;
    localparam logic [7:0] POS_REG    = 8'd36;
    localparam logic [7:0] MOVING_REG = 8'd46;

    // Status packet constants
    localparam logic [7:0] SYNC_BYTE       = 8'hFF;
    localparam logic [7:0] ERR_INSTRUCTION = 8'h40;
    localparam logic [7:0] ERR_NONE        = 8'h00;
    localparam logic [7:0] LEN_BASE        = 8'd2;

    // Angle scaling
    localparam logic [7:0]  MAX_ANGLE       = 8'd180;
    localparam logic [15:0] GOAL_FULL_SCALE = 16'd1023;
    // floor(x/45) = (x * POS_RECIP) >> POS_SHIFT, exact for x <= 180*256
    localparam logic [15:0] POS_RECIP       = 16'd46604;
    localparam int          POS_SHIFT       = 21;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    typedef logic [CFG_ADDR_W-3:0] cfg_index_t;
    localparam cfg_index_t REG_SERVO_ID      = 1'b0;
    localparam cfg_index_t REG_MS_PER_DEGREE = 1'b1;
    localparam logic [7:0] SERVO_ID_RESET    = 8'd1;
    localparam logic [7:0] MS_PER_DEG_RESET  = 8'd20;

    // One reply waiting to be serialized
    typedef struct packed {
        logic       err_instr;
        logic [1:0] npar;
        logic [7:0] par0;
        logic [7:0] par1;
    } desc_t;

    // Queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: hdl/sbsr_front.sv
// ----------------------------------------------------------------------------
// sbsr_front
// Accepts items, classifies them, keeps time and position state and queues
// one reply descriptor for every instruction that is answered.
// ----------------------------------------------------------------------------
module sbsr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic                frame_ok,
    input  logic [7:0]          target_id,
    input  logic [7:0]          instr_code,
    input  logic [7:0]          reg_addr,
    input  logic [15:0]         write_value,
    input  logic [7:0]          servo_id,
    input  logic [7:0]          ms_per_degree,
    input  sbsr_pkg::q_status_t q_status,
    output logic                push,
    output sbsr_pkg::desc_t     push_desc
);

    typedef enum logic [2:0] {
        CLS_TICK,
        CLS_IGNORE,
        CLS_PING,
        CLS_GOAL,
        CLS_MOVING,
        CLS_POSITION,
        CLS_BAD
    } item_class_t;

    item_class_t class_in;
    logic [7:0]  goal_in;
    logic [17:0] scaled;
    logic [7:0]  quot0;
    logic [10:0] rem;

    logic        s1_valid_reg;
    item_class_t s1_class_reg;
    logic [7:0]  s1_goal_reg;

    logic [31:0] now_ms_reg;
    logic [7:0]  angle_reg;
    logic [31:0] arrival_reg;

    logic        emits;
    logic        fire;
    logic [7:0]  diff;
    logic [15:0] move_ms;
    logic [31:0] pos_prod;
    logic [10:0] pos_val;

    // Classify the incoming item
    always_comb
    begin
        if (!op)
            class_in = CLS_TICK;
        else if (!frame_ok || target_id != servo_id)
            class_in = CLS_IGNORE;
        else if (instr_code == sbsr_pkg::INS_PING)
            class_in = CLS_PING;
        else if (instr_code == sbsr_pkg::INS_WRITE && reg_addr == sbsr_pkg::GOAL_REG)
            class_in = CLS_GOAL;
        else if (instr_code == sbsr_pkg::INS_READ && reg_addr == sbsr_pkg::MOVING_REG)
            class_in = CLS_MOVING;
        else if (instr_code == sbsr_pkg::INS_READ && reg_addr == sbsr_pkg::POS_REG)
            class_in = CLS_POSITION;
        else
            class_in = CLS_BAD;
    end

    // Goal angle: floor(v*180/1023), max 180; v*180=q*1024+lo=q*1023+(q+lo)
    always_comb
    begin
        scaled = {8'b0, write_value[9:0]} * 18'(sbsr_pkg::MAX_ANGLE);
        quot0  = scaled[17:10];
        rem    = {1'b0, scaled[9:0]} + {3'b0, quot0};
        if (write_value >= sbsr_pkg::GOAL_FULL_SCALE)
            goal_in = sbsr_pkg::MAX_ANGLE;
        else if (rem >= 11'(sbsr_pkg::GOAL_FULL_SCALE))
            goal_in = quot0 + 8'd1;
        else
            goal_in = quot0;
    end

    // Stage handshake: an answered item waits for queue space
    assign emits    = (s1_class_reg != CLS_TICK) && (s1_class_reg != CLS_IGNORE);
    assign fire     = s1_valid_reg && (!emits || !q_status.full);
    assign in_ready = !s1_valid_reg || fire;
    assign push     = fire && emits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_class_reg <= class_in;
            s1_goal_reg  <= goal_in;
        end
    end

    // Move time and present position
    always_comb
    begin
        diff     = (s1_goal_reg > angle_reg) ? (s1_goal_reg - angle_reg)
                                             : (angle_reg - s1_goal_reg);
        move_ms  = {8'b0, diff} * {8'b0, ms_per_degree};
        pos_prod = {8'b0, angle_reg, 16'b0} >> 8;
        pos_prod = pos_prod * {16'b0, sbsr_pkg::POS_RECIP};
        pos_val  = 11'(pos_prod >> sbsr_pkg::POS_SHIFT);
    end

    // State update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_ms_reg  <= 32'd0;
            angle_reg   <= 8'd0;
            arrival_reg <= 32'd0;
        end
        else if (fire)
        begin
            case (s1_class_reg)
                CLS_TICK:
                begin
                    now_ms_reg <= now_ms_reg + 32'd1;
                end
                CLS_GOAL:
                begin
                    angle_reg   <= s1_goal_reg;
                    arrival_reg <= now_ms_reg + {16'b0, move_ms};
                end
                default:
                begin
                end
            endcase
        end
    end

    // Reply descriptor
    always_comb
    begin
        push_desc = '0;
        case (s1_class_reg)
            CLS_MOVING:
            begin
                push_desc.npar = 2'd1;
                push_desc.par0 = {7'b0, (now_ms_reg < arrival_reg)};
            end
            CLS_POSITION:
            begin
                push_desc.npar = 2'd2;
                push_desc.par0 = pos_val[7:0];
                push_desc.par1 = {5'b0, pos_val[10:8]};
            end
            CLS_BAD:
            begin
                push_desc.err_instr = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: hdl/sbsr_desc_queue.sv
// ----------------------------------------------------------------------------
// sbsr_desc_queue
// Short first-in first-out queue of reply descriptors between the front
// and the serializer; the head is readable in the cycle it is popped.
// ----------------------------------------------------------------------------
module sbsr_desc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sbsr_pkg::desc_t     push_desc,
    input  logic                pop,
    output sbsr_pkg::desc_t     head,
    output sbsr_pkg::q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sbsr_pkg::desc_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_desc;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// File: hdl/sbsr_back.sv
// ----------------------------------------------------------------------------
// sbsr_back
// Serializes one reply descriptor at a time into a status packet, with a
// running checksum and a registered output.
// ----------------------------------------------------------------------------
module sbsr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          servo_id,
    input  sbsr_pkg::desc_t     head,
    input  sbsr_pkg::q_status_t q_status,
    output logic                pop,
    output logic                busy,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                last_byte
);

    // Byte positions within a packet
    localparam logic [2:0] BYTE_SYNC0 = 3'd0;
    localparam logic [2:0] BYTE_SYNC1 = 3'd1;
    localparam logic [2:0] BYTE_ID    = 3'd2;
    localparam logic [2:0] BYTE_LEN   = 3'd3;
    localparam logic [2:0] BYTE_ERR   = 3'd4;
    localparam logic [2:0] BYTE_PAR0  = 3'd5;

    logic            cur_valid_reg;
    sbsr_pkg::desc_t cur_desc_reg;
    logic [2:0]      idx_reg;
    logic [7:0]      sum_reg;
    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            out_last_reg;

    logic            advance;
    logic            cur_last;
    logic            load;
    logic [7:0]      cur_byte;

    assign advance = cur_valid_reg && (!out_valid_reg || out_ready);
    assign cur_last = (idx_reg == BYTE_PAR0 + {1'b0, cur_desc_reg.npar});
    assign load    = !cur_valid_reg || (advance && cur_last);
    assign pop     = load && !q_status.empty;
    assign busy    = cur_valid_reg;

    // Select the byte at the current position
    always_comb
    begin
        case (idx_reg)
            BYTE_SYNC0, BYTE_SYNC1:
                cur_byte = sbsr_pkg::SYNC_BYTE;
            BYTE_ID:
                cur_byte = servo_id;
            BYTE_LEN:
                cur_byte = {6'b0, cur_desc_reg.npar} + sbsr_pkg::LEN_BASE;
            BYTE_ERR:
                cur_byte = cur_desc_reg.err_instr ? sbsr_pkg::ERR_INSTRUCTION
                                                  : sbsr_pkg::ERR_NONE;
            default:
            begin
                if (cur_last)
                    cur_byte = ~sum_reg;
                else if (idx_reg == BYTE_PAR0)
                    cur_byte = cur_desc_reg.par0;
                else
                    cur_byte = cur_desc_reg.par1;
            end
        endcase
    end

    // Packet sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= BYTE_SYNC0;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= BYTE_SYNC0;
        end
        else if (advance && cur_last)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // Descriptor and checksum, no reset needed
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_desc_reg <= head;
        if (advance)
        begin
            if (idx_reg == BYTE_ID)
                sum_reg <= cur_byte;
            else
                sum_reg <= sum_reg + cur_byte;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= cur_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = out_last_reg;

endmodule

// File: hdl/servo_bus_status_responder.sv
// ----------------------------------------------------------------------------
// servo_bus_status_responder
// Status packet responder for one device id on a servo bus.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless the front stalls: ticks,
// ignored instructions and answered instructions all enter back to back
// through a one-stage front that updates the time and position state.
// Each answered instruction queues a descriptor, and the packet serializer
// then sends its reply at one byte per cycle while out_ready is high, so
// under a steady stream of answered instructions the sustained rate is set
// by the serializer's output port. A reply passes the front stage register,
// the descriptor queue and the serializer's output register. The queue
// holds QUEUE_DEPTH replies; the front stalls only when it is full.
module servo_bus_status_responder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbsr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic                          frame_ok,
    input  logic [7:0]                    target_id,
    input  logic [7:0]                    instr_code,
    input  logic [7:0]                    reg_addr,
    input  logic [15:0]                   write_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_byte,
    output logic                          last_byte
);

    logic [7:0]           servo_id_reg;
    logic [7:0]           ms_per_degree_reg;
    sbsr_pkg::cfg_index_t cfg_index;
    logic                 cfg_write;

    logic                 push;
    logic                 pop;
    logic                 back_busy;
    sbsr_pkg::desc_t      push_desc;
    sbsr_pkg::desc_t      head;
    sbsr_pkg::q_status_t  q_status;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_index = paddr[sbsr_pkg::CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_id_reg      <= sbsr_pkg::SERVO_ID_RESET;
            ms_per_degree_reg <= sbsr_pkg::MS_PER_DEG_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sbsr_pkg::REG_SERVO_ID:      servo_id_reg      <= pwdata[7:0];
                sbsr_pkg::REG_MS_PER_DEGREE: ms_per_degree_reg <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            sbsr_pkg::REG_SERVO_ID:      prdata = {24'b0, servo_id_reg};
            sbsr_pkg::REG_MS_PER_DEGREE: prdata = {24'b0, ms_per_degree_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // Front: classify and update state
    sbsr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .frame_ok      (frame_ok),
        .target_id     (target_id),
        .instr_code    (instr_code),
        .reg_addr      (reg_addr),
        .write_value   (write_value),
        .servo_id      (servo_id_reg),
        .ms_per_degree (ms_per_degree_reg),
        .q_status      (q_status),
        .push          (push),
        .push_desc     (push_desc)
    );

    // Reply descriptor queue
    sbsr_desc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // Back: packet serializer
    sbsr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .servo_id  (servo_id_reg),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .busy      (back_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

    // Front stalls only on a full queue
    a_stall_only_when_full : assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_status.full
    ) else $error("front stalled while the descriptor queue had space");

    // Queue fills only while the serializer is sending a packet
    a_full_means_busy : assert property (
        @(posedge clk) disable iff (!rst_n)
        q_status.full |-> back_busy
    ) else $error("descriptor queue full while serializer idle");

    // No push into a full queue
    a_no_overflow : assert property (
        @(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full
    ) else $error("descriptor pushed into a full queue");

    // An idle serializer loads a descriptor right after the queue becomes non-empty
    a_prompt_load : assert property (
        @(posedge clk) disable iff (!rst_n)
        (!back_busy && !q_status.empty) |=> back_busy
    ) else $error("serializer did not take a waiting descriptor");

endmodule

// File: tb/tb_servo_bus_status_responder.sv
// ----------------------------------------------------------------------------
// tb_servo_bus_status_responder
// Self-checking bench for the servo-bus status responder. Items go in over
// a valid/ready channel. Each status byte that comes out is checked against
// a local prediction of the reply packets. The run covers pings, goal
// writes, position and moving reads, rejected requests, id filtering and
// several register settings, then random traffic with random stalls.
// ----------------------------------------------------------------------------
module tb_servo_bus_status_responder;

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 20;

    // One input item, one field per port
    typedef struct {
        logic        op;
        logic        frame_ok;
        logic [7:0]  target_id;
        logic [7:0]  instr_code;
        logic [7:0]  reg_addr;
        logic [15:0] write_value;
    } servo_item_t;

    // One expected status byte
    typedef struct {
        logic [7:0] data;
        logic       last;
    } status_byte_t;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [sbsr_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;
    logic                            in_valid;
    logic                            in_ready;
    logic                            op;
    logic                            frame_ok;
    logic [7:0]                      target_id;
    logic [7:0]                      instr_code;
    logic [7:0]                      reg_addr;
    logic [15:0]                     write_value;
    logic                            out_valid;
    logic                            out_ready;
    logic [7:0]                      out_byte;
    logic                            last_byte;

    // Predicted device state and register copies
    logic [7:0]  cur_id;
    logic [7:0]  cur_rate;
    logic [31:0] clock_ms;
    logic [7:0]  angle_deg;
    logic [31:0] arrive_ms;

    status_byte_t status_bytes[$];

    int  fail_count;
    int  items_sent;
    int  ticks_sent;
    int  bytes_checked;
    int  replies_checked;
    int  reg_writes;
    int  quiet_cycles;
    bit  steady;

    servo_bus_status_responder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .frame_ok    (frame_ok),
        .target_id   (target_id),
        .instr_code  (instr_code),
        .reg_addr    (reg_addr),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_byte   (last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Mostly short gaps, a few long ones; none in steady stretches
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] exp_v,
                                          logic [31:0] act_v);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH %s: expected %0h, got %0h", what, exp_v, act_v);
    endfunction

    function automatic servo_item_t make_instr(logic [7:0] tid, logic [7:0] ins,
                                               logic [7:0] addr, logic [15:0] val);
        servo_item_t it;
        it.op          = 1'b1;
        it.frame_ok    = 1'b1;
        it.target_id   = tid;
        it.instr_code  = ins;
        it.reg_addr    = addr;
        it.write_value = val;
        return it;
    endfunction

    // Tick with junk in the other fields, which a tick ignores
    function automatic servo_item_t make_tick();
        servo_item_t it;
        it.op          = 1'b0;
        it.frame_ok    = 1'($urandom);
        it.target_id   = 8'($urandom);
        it.instr_code  = 8'($urandom);
        it.reg_addr    = 8'($urandom);
        it.write_value = 16'($urandom);
        return it;
    endfunction

    // Queue one status packet: FF FF id len err params cksum
    function automatic void push_status(logic [7:0] err, int npar,
                                        logic [7:0] p0, logic [7:0] p1);
        logic [7:0] sum;
        logic [7:0] body[$];
        body = '{cur_id, 8'(npar) + sbsr_pkg::LEN_BASE, err};
        if (npar > 0)
            body.push_back(p0);
        if (npar > 1)
            body.push_back(p1);
        status_bytes.push_back('{sbsr_pkg::SYNC_BYTE, 1'b0});
        status_bytes.push_back('{sbsr_pkg::SYNC_BYTE, 1'b0});
        sum = 8'd0;
        foreach (body[k])
        begin
            sum += body[k];
            status_bytes.push_back('{body[k], 1'b0});
        end
        status_bytes.push_back('{~sum, 1'b1});
    endfunction

    // Predict the reply of one accepted item and update the state copy
    function automatic void answer_item(servo_item_t it);
        logic [31:0] goal;
        logic [31:0] pos;
        logic [7:0]  delta;
        if (it.op == 1'b0)
        begin
            clock_ms = clock_ms + 32'd1;
            return;
        end
        if (!it.frame_ok || it.target_id != cur_id)
            return;
        if (it.instr_code == sbsr_pkg::INS_PING)
            push_status(sbsr_pkg::ERR_NONE, 0, 8'd0, 8'd0);
        else if (it.instr_code == sbsr_pkg::INS_WRITE && it.reg_addr == sbsr_pkg::GOAL_REG)
        begin
            goal = ({16'd0, it.write_value} * 32'd180) / 32'd1023;
            if (goal > 32'(sbsr_pkg::MAX_ANGLE))
                goal = 32'(sbsr_pkg::MAX_ANGLE);
            delta = (goal[7:0] > angle_deg) ? goal[7:0] - angle_deg
                                            : angle_deg - goal[7:0];
            angle_deg = goal[7:0];
            arrive_ms = clock_ms + {24'd0, cur_rate} * {24'd0, delta};
            push_status(sbsr_pkg::ERR_NONE, 0, 8'd0, 8'd0);
        end
        else if (it.instr_code == sbsr_pkg::INS_READ && it.reg_addr == sbsr_pkg::MOVING_REG)
            push_status(sbsr_pkg::ERR_NONE, 1, (clock_ms < arrive_ms) ? 8'd1 : 8'd0, 8'd0);
        else if (it.instr_code == sbsr_pkg::INS_READ && it.reg_addr == sbsr_pkg::POS_REG)
        begin
            pos = ({24'd0, angle_deg} * 32'd1024) / 32'd180;
            push_status(sbsr_pkg::ERR_NONE, 2, pos[7:0], pos[15:8]);
        end
        else
            push_status(sbsr_pkg::ERR_INSTRUCTION, 0, 8'd0, 8'd0);
    endfunction

    // Send one item; valid is left high so a following item can go back to back
    task automatic send_item(servo_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= it.op;
        frame_ok    <= it.frame_ok;
        target_id   <= it.target_id;
        instr_code  <= it.instr_code;
        reg_addr    <= it.reg_addr;
        write_value <= it.write_value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        answer_item(it);
        if (it.op == 1'b0)
            ticks_sent++;
        else
            items_sent++;
    endtask

    task automatic send_ticks(int count);
        repeat (count) send_item(make_tick());
    endtask

    // Wait for every expected byte, then let any tick still in the front finish
    task automatic settle();
        in_valid <= 1'b0;
        while (status_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write while idle, then read it back
    task automatic write_register(sbsr_pkg::cfg_index_t idx, logic [7:0] val);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == sbsr_pkg::REG_SERVO_ID)
            cur_id = val;
        else
            cur_rate = val;
        reg_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {24'd0, val})
            note_mismatch("register readback", {24'd0, val}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Output side: check each accepted byte, then choose the next ready level
    // ------------------------------------------------------------------------
    initial
    begin
        int           hold_left;
        status_byte_t exp_b;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (status_bytes.size() == 0)
                    note_mismatch("unexpected status byte", 32'd0, {24'd0, out_byte});
                else
                begin
                    exp_b = status_bytes.pop_front();
                    bytes_checked++;
                    if (out_byte !== exp_b.data)
                        note_mismatch("out_byte", {24'd0, exp_b.data}, {24'd0, out_byte});
                    if (last_byte !== exp_b.last)
                        note_mismatch("last_byte", {31'd0, exp_b.last},
                                      {31'd0, last_byte});
                    if (exp_b.last)
                        replies_checked++;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (steady || $urandom_range(0, 99) < 75)
                out_ready <= 1'b1;
            else
            begin
                hold_left = pick_gap();
                out_ready <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with no transfer on any port
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
        $display("tb_servo_bus_status_responder failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Ping, and requests that must be dropped
    task automatic test_ping_and_filter();
        servo_item_t it;
        send_item(make_instr(cur_id, sbsr_pkg::INS_PING, 8'd0, 16'd0));
        it = make_instr(cur_id, sbsr_pkg::INS_PING, 8'd0, 16'd0);
        it.frame_ok = 1'b0;
        send_item(it);
        send_item(make_instr(8'd0, sbsr_pkg::INS_PING, 8'd0, 16'd0));
        send_item(make_instr(8'd254, sbsr_pkg::INS_PING, 8'd0, 16'd0));
        send_item(make_instr(8'd255, sbsr_pkg::INS_READ, sbsr_pkg::POS_REG, 16'hFFFF));
        send_ticks(2);
        send_item(make_instr(cur_id, sbsr_pkg::INS_PING, 8'hFF, 16'hFFFF));
    endtask

    // Goal extremes, saturation and position readback
    task automatic test_goal_and_position();
        send_item(make_instr(cur_id, sbsr_pkg::INS_READ, sbsr_pkg::POS_REG, 16'd0));
        send_item(make_instr(cur_id, sbsr_pkg::INS_WRITE, sbsr_pkg::GOAL_REG, 16'd1023));
        send_item(make_instr(cur_id, sbsr_pkg::INS_READ, sbsr_pkg::POS_REG, 16'd0));
        send_item(make_instr(cur_id, sbsr_pkg::INS_WRITE, sbsr_pkg::GOAL_REG, 16'hFFFF));
        send_item(make_instr(cur_id, sbsr_pkg::INS_READ, sbsr_pkg::POS_REG, 16'd0));
        send_item(make_instr(cur_id, sbsr_pkg::INS_WRITE, sbsr_pkg::GOAL_REG, 16'd512));
        send_item(make_instr(cur_id, sbsr_pkg::INS_READ, sbsr_pkg::POS_REG, 16'd0));
        send_item(make_instr(cur_id, sbsr_pkg::INS_WRITE, sbsr_pkg::GOAL_REG, 16'd5));
        send_item(make_instr(cur_id, sbsr_pkg::INS_READ, sbsr_pkg::POS_REG, 16'd0));
    endtask

    // Moving flag right at the arrival boundary (one degree at the reset rate)
    task automatic test_moving_flag();
        send_item(make_instr(cur_id, sbsr_pkg::INS_WRITE, sbsr_pkg::GOAL_REG, 16'd6));
        send_item(make_instr(cur_id, sbsr_pkg::INS_READ, sbsr_pkg::MOVING_REG, 16'd0));
        send_ticks(19);
        send_item(make_instr(cur_id, sbsr_pkg::INS_READ, sbsr_pkg::MOVING_REG, 16'd0));
        send_ticks(1);
        send_item(make_instr(cur_id, sbsr_pkg::INS_READ, sbsr_pkg::MOVING_REG, 16'd0));
    endtask

    // Unknown instructions and reads or writes of other addresses
    task automatic test_bad_requests();
        send_item(make_instr(cur_id, 8'd0, sbsr_pkg::GOAL_REG, 16'd100));
        send_item(make_instr(cur_id, 8'd255, sbsr_pkg::POS_REG, 16'd100));
        send_item(make_instr(cur_id, 8'd4, sbsr_pkg::MOVING_REG, 16'd100));
        send_item(make_instr(cur_id, sbsr_pkg::INS_READ, sbsr_pkg::GOAL_REG, 16'd0));
        send_item(make_instr(cur_id, sbsr_pkg::INS_READ, 8'd0, 16'd0));
        send_item(make_instr(cur_id, sbsr_pkg::INS_WRITE, sbsr_pkg::POS_REG, 16'd1023));
        send_item(make_instr(cur_id, sbsr_pkg::INS_WRITE, sbsr_pkg::MOVING_REG, 16'd1023));
        send_item(make_instr(cur_id, sbsr_pkg::INS_WRITE, 8'hFF, 16'd1023));
        send_item(make_instr(cur_id, sbsr_pkg::INS_READ, sbsr_pkg::POS_REG, 16'd0));
    endtask

    // Extreme ids and rotation rates
    task automatic test_register_settings();
        write_register(sbsr_pkg::REG_SERVO_ID, 8'd0);
        send_item(make_instr(8'd0, sbsr_pkg::INS_PING, 8'd0, 16'd0));
        send_item(make_instr(8'd1, sbsr_pkg::INS_PING, 8'd0, 16'd0));
        write_register(sbsr_pkg::REG_SERVO_ID, 8'd253);
        send_item(make_instr(8'd253, sbsr_pkg::INS_READ, sbsr_pkg::POS_REG, 16'd0));
        send_item(make_instr(8'd0, sbsr_pkg::INS_PING, 8'd0, 16'd0));
        write_register(sbsr_pkg::REG_MS_PER_DEGREE, 8'd0);
        send_item(make_instr(cur_id, sbsr_pkg::INS_WRITE, sbsr_pkg::GOAL_REG, 16'd1023));
        send_item(make_instr(cur_id, sbsr_pkg::INS_READ, sbsr_pkg::MOVING_REG, 16'd0));
        write_register(sbsr_pkg::REG_MS_PER_DEGREE, 8'd255);
        send_item(make_instr(cur_id, sbsr_pkg::INS_WRITE, sbsr_pkg::GOAL_REG, 16'd0));
        send_item(make_instr(cur_id, sbsr_pkg::INS_READ, sbsr_pkg::MOVING_REG, 16'd0));
        send_ticks(3);
        send_item(make_instr(cur_id, sbsr_pkg::INS_READ, sbsr_pkg::MOVING_REG, 16'd0));
    endtask

    // Mostly well-formed requests for this id, plus tick bursts and noise
    task automatic test_random_traffic(logic [7:0] id_val, logic [7:0] rate_val);
        servo_item_t it;
        int          r;
        write_register(sbsr_pkg::REG_SERVO_ID, id_val);
        write_register(sbsr_pkg::REG_MS_PER_DEGREE, rate_val);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n < 12);
            r = $urandom_range(0, 99);
            if (r < 12)
                send_ticks($urandom_range(1, 8));
            if (r >= 12 && r < 30)
            begin
                it.op          = 1'($urandom);
                it.frame_ok    = 1'($urandom);
                it.target_id   = ($urandom_range(0, 3) == 0) ? cur_id : 8'($urandom);
                it.instr_code  = 8'($urandom);
                it.reg_addr    = 8'($urandom);
                it.write_value = 16'($urandom);
            end
            else
            begin
                it = make_instr(cur_id, sbsr_pkg::INS_PING, 8'($urandom), 16'($urandom));
                case ($urandom_range(0, 9))
                    0:
                        it.instr_code = sbsr_pkg::INS_PING;
                    1, 2, 3:
                    begin
                        it.instr_code = sbsr_pkg::INS_WRITE;
                        it.reg_addr   = sbsr_pkg::GOAL_REG;
                        if ($urandom_range(0, 3) != 0)
                            it.write_value = 16'($urandom_range(0, 1023));
                    end
                    4, 5:
                    begin
                        it.instr_code = sbsr_pkg::INS_READ;
                        it.reg_addr   = sbsr_pkg::MOVING_REG;
                    end
                    6, 7:
                    begin
                        it.instr_code = sbsr_pkg::INS_READ;
                        it.reg_addr   = sbsr_pkg::POS_REG;
                    end
                    default:
                        it.instr_code = 8'($urandom_range(0, 4));
                endcase
            end
            send_item(it);
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        fail_count      = 0;
        items_sent      = 0;
        ticks_sent      = 0;
        bytes_checked   = 0;
        replies_checked = 0;
        reg_writes      = 0;
        quiet_cycles    = 0;
        steady          = 1'b0;
        status_bytes.delete();

        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= 32'd0;
        in_valid    <= 1'b0;
        op          <= 1'b0;
        frame_ok    <= 1'b0;
        target_id   <= 8'd0;
        instr_code  <= 8'd0;
        reg_addr    <= 8'd0;
        write_value <= 16'd0;

        cur_id    = sbsr_pkg::SERVO_ID_RESET;
        cur_rate  = sbsr_pkg::MS_PER_DEG_RESET;
        clock_ms  = 32'd0;
        angle_deg = 8'd0;
        arrive_ms = 32'd0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ping_and_filter();
        test_goal_and_position();
        test_moving_flag();
        test_bad_requests();
        test_register_settings();
        test_random_traffic(8'($urandom_range(0, 253)), 8'd1);
        test_random_traffic(8'd253, 8'($urandom_range(0, 255)));
        test_random_traffic(8'd0, 8'd255);

        settle();
        if (status_bytes.size() != 0)
            note_mismatch("status bytes never sent", 32'd0, status_bytes.size());

        $display("Sent %0d instructions and %0d ticks over %0d register writes;",
                 items_sent, ticks_sent, reg_writes);
        $display("checked %0d status bytes in %0d reply packets, %0d mismatches.",
                 bytes_checked, replies_checked, fail_count);
        if (fail_count == 0)
            $display("tb_servo_bus_status_responder passed");
        else
            $display("tb_servo_bus_status_responder failed");
        $finish;
    end

endmodule
